[src/bst_pkg.sv]
`timescale 1ns / 1ps

package bst_pkg;

    localparam int GUESTS  = 2;
    localparam int SLOTS   = 16;
    localparam int ENTRY_N = GUESTS * SLOTS;
    localparam int GUEST_W = 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = (ENTRY_N > 1) ? $clog2(ENTRY_N) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ADDR_W  = 32;
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAN = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_NEW    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MERGED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FOUND  = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_KEPT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_GONE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADCMD = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    typedef struct packed {
        t_cmd                command;
        logic [GUEST_W-1:0]  guest_id;
        logic [ADDR_W-1:0]   address;
        logic [KIND_W-1:0]   kind_mask;
        logic [WORD_W-1:0]   original_word;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [KIND_W-1:0]   kinds_out;
        logic [WORD_W-1:0]   saved_word;
    } t_res;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [KIND_W-1:0]   kinds;
        logic [WORD_W-1:0]   word;
    } t_slot;

    typedef struct packed {
        logic                en;
        logic [ENTRY_W-1:0]  addr;
    } t_rd_req;

    typedef struct packed {
        logic                en;
        logic [ENTRY_W-1:0]  addr;
        t_slot               data;
    } t_wr_req;

    function automatic logic [ENTRY_W-1:0] entry_of(input logic [GUEST_W-1:0] g,
                                                    input logic [SLOT_W-1:0] s);
        int e;
        e = int'(g) * SLOTS + int'(s);
        return ENTRY_W'(e);
    endfunction

    function automatic logic guest_ok(input logic [GUEST_W-1:0] g);
        return int'(g) < GUESTS;
    endfunction

endpackage

[src/bst_slot_mem.sv]
`timescale 1ns / 1ps

module bst_slot_mem (
    input  logic             i_clk,
    input  bst_pkg::t_rd_req i_rd,
    input  bst_pkg::t_wr_req i_wr,
    output bst_pkg::t_slot   o_rd_data
);

    bst_pkg::t_slot r_mem [bst_pkg::ENTRY_N];
    bst_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/bst_ctrl.sv]
`timescale 1ns / 1ps

module bst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_vld,
    input  bst_pkg::t_req    i_req,
    output logic             o_ready,
    input  logic             i_out_free,
    output logic             o_res_load,
    output bst_pkg::t_res    o_res,
    output bst_pkg::t_rd_req o_rd,
    input  bst_pkg::t_slot   i_rd_data,
    output bst_pkg::t_wr_req o_wr
);

    bst_pkg::t_state                 r_state, n_state;
    bst_pkg::t_req                   r_req;
    logic [bst_pkg::ENTRY_N-1:0]     r_valid;
    logic [bst_pkg::CNT_W-1:0]       r_cnt;
    logic                            r_chk;
    logic [bst_pkg::SLOT_W-1:0]      r_chk_slot;
    logic                            r_rd_valid;
    logic                            r_found;
    logic [bst_pkg::SLOT_W-1:0]      r_hit_slot;
    logic [bst_pkg::KIND_W-1:0]      r_hit_kinds;
    logic [bst_pkg::WORD_W-1:0]      r_hit_word;
    logic                            r_have_free;
    logic [bst_pkg::SLOT_W-1:0]      r_free_slot;

    logic                            accept;
    logic                            issue;
    logic                            hit;
    logic                            apply;
    logic [bst_pkg::SLOT_W-1:0]      scan_slot;
    logic                            valid_set;
    logic                            valid_clr;
    logic [bst_pkg::KIND_W-1:0]      merge_kinds;
    logic [bst_pkg::KIND_W-1:0]      clean_kinds;

    assign scan_slot   = r_cnt[bst_pkg::SLOT_W-1:0];
    assign hit         = r_chk && r_rd_valid && (i_rd_data.address == r_req.address);
    assign merge_kinds = r_hit_kinds | r_req.kind_mask;
    assign clean_kinds = r_hit_kinds & ~r_req.kind_mask;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bst_pkg::S_IDLE: begin
                if (i_req_vld) begin
                    if (i_req.command != bst_pkg::CMD_NONE && bst_pkg::guest_ok(i_req.guest_id))
                        n_state = bst_pkg::S_SCAN;
                    else
                        n_state = bst_pkg::S_APPLY;
                end
            end
            bst_pkg::S_SCAN: begin
                if (r_cnt == bst_pkg::CNT_W'(bst_pkg::SLOTS) && r_chk) begin
                    n_state = bst_pkg::S_APPLY;
                end
            end
            bst_pkg::S_APPLY: begin
                if (i_out_free) begin
                    n_state = bst_pkg::S_IDLE;
                end
            end
            default: n_state = bst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        issue      = 1'b0;
        apply      = 1'b0;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        o_wr       = '0;
        o_res      = '0;
        case (r_state)
            bst_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            bst_pkg::S_SCAN: begin
                issue = (r_cnt < bst_pkg::CNT_W'(bst_pkg::SLOTS));
            end
            bst_pkg::S_APPLY: begin
                apply = i_out_free;
                o_wr.data.address = r_req.address;
                o_wr.data.word    = r_hit_word;
                o_wr.addr         = bst_pkg::entry_of(r_req.guest_id, r_hit_slot);
                case (r_req.command)
                    bst_pkg::CMD_STORE: begin
                        if (r_found) begin
                            o_wr.en          = apply;
                            o_wr.data.kinds  = merge_kinds;
                            o_res.status     = bst_pkg::ST_MERGED;
                            o_res.kinds_out  = merge_kinds;
                            o_res.saved_word = r_hit_word;
                        end else if (r_have_free) begin
                            o_wr.en          = apply;
                            o_wr.addr        = bst_pkg::entry_of(r_req.guest_id, r_free_slot);
                            o_wr.data.kinds  = r_req.kind_mask;
                            o_wr.data.word   = r_req.original_word;
                            valid_set        = apply;
                            o_res.status     = bst_pkg::ST_NEW;
                            o_res.kinds_out  = r_req.kind_mask;
                            o_res.saved_word = r_req.original_word;
                        end else begin
                            o_res.status     = bst_pkg::ST_FULL;
                        end
                    end
                    bst_pkg::CMD_QUERY: begin
                        if (r_found) begin
                            o_res.status     = bst_pkg::ST_FOUND;
                            o_res.kinds_out  = r_hit_kinds;
                            o_res.saved_word = r_hit_word;
                        end else begin
                            o_res.status     = bst_pkg::ST_MISS;
                        end
                    end
                    bst_pkg::CMD_CLEAN: begin
                        if (r_found) begin
                            o_wr.en          = apply;
                            o_wr.data.kinds  = clean_kinds;
                            o_res.saved_word = r_hit_word;
                            if (clean_kinds == '0) begin
                                valid_clr    = apply;
                                o_res.status = bst_pkg::ST_FREED;
                            end else begin
                                o_res.status    = bst_pkg::ST_KEPT;
                                o_res.kinds_out = clean_kinds;
                            end
                        end else begin
                            o_res.status = bst_pkg::ST_GONE;
                        end
                    end
                    default: begin
                        o_res.status = bst_pkg::ST_BADCMD;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign accept     = o_ready && i_req_vld;
    assign o_res_load = apply;
    assign o_rd.en    = issue;
    assign o_rd.addr  = bst_pkg::entry_of(r_req.guest_id, scan_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bst_pkg::S_IDLE;
            r_valid <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= issue;
            if (valid_set) begin
                r_valid[o_wr.addr] <= 1'b1;
            end
            if (valid_clr) begin
                r_valid[o_wr.addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req       <= i_req;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (hit && !r_found) begin
                r_found     <= 1'b1;
                r_hit_slot  <= r_chk_slot;
                r_hit_kinds <= i_rd_data.kinds;
                r_hit_word  <= i_rd_data.word;
            end
            if (r_chk && !r_rd_valid && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_slot <= r_chk_slot;
            end
        end
        if (issue) begin
            r_chk_slot <= scan_slot;
            r_rd_valid <= r_valid[o_rd.addr];
        end
    end

endmodule

[src/breakpoint_slot_table.sv]
`timescale 1ns / 1ps
// Breakpoint slot table: per-guest slots holding an address, trap kinds and a saved word.
// Command transaction on the s_axis group: tuser carries command and guest, tdata carries
// address, kind mask and original instruction word. Each command gives exactly one result
// transaction on the m_axis group: status, trap kinds and saved word.
// One command at a time: after acceptance the sequencer reads the guest's slots one per
// cycle through a single read port of the slot memory and one address comparator, finds
// the first matching slot and the lowest free slot, then writes back and loads the result.
// The result is loaded after all SLOTS slots are scanned, and ready returns only after the
// result is loaded, so no command is accepted while another is in progress. An unused
// command code or an unknown guest skips the scan and answers as soon as the output is free.
// Reset clears all slot valid bits and the output valid flag; slot contents and output data are left as is.
// The result sits in an output register; if it is not taken, the next command is still
// accepted and scanned, and its write-back waits until the output register frees up.
module breakpoint_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // address[31:0], kind_mask[34:32], original_word[66:35]
    input  logic [2:0]  i_s_tuser,  // command[1:0], guest_id[2]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // status[1:0], kinds_out[4:2], saved_word[36:5]
);

    bst_pkg::t_req     req;
    bst_pkg::t_res     res;
    bst_pkg::t_rd_req  rd;
    bst_pkg::t_wr_req  wr;
    bst_pkg::t_slot    rd_data;
    logic              res_load;
    logic              out_free;
    logic              r_out_vld;
    bst_pkg::t_res     r_out;

    assign req.command       = bst_pkg::t_cmd'(i_s_tuser[1:0]);
    assign req.guest_id      = i_s_tuser[2];
    assign req.address       = i_s_tdata[31:0];
    assign req.kind_mask     = i_s_tdata[34:32];
    assign req.original_word = i_s_tdata[66:35];

    assign out_free = !r_out_vld || i_m_tready;

    bst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_vld  (i_s_tvalid),
        .i_req      (req),
        .o_ready    (o_s_tready),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res),
        .o_rd       (rd),
        .i_rd_data  (rd_data),
        .o_wr       (wr)
    );

    bst_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_rd      (rd),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out.saved_word, r_out.kinds_out, r_out.status};

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_out_vld || i_m_tready))
        else $error("result loaded over a pending result");

    a_accept_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> !res_load)
        else $error("command accepted while a result is loaded");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after a command was accepted");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!wr.en && !rd.en))
        else $error("slot memory accessed while idle");

endmodule

[verif/breakpoint_slot_table_test.sv]
`timescale 1ns / 1ps

module breakpoint_slot_table_test;

    localparam int POOL_N     = 22;
    localparam int RAND_ITEMS = 1750;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        bst_pkg::t_cmd                cmd;
        logic [bst_pkg::GUEST_W-1:0]  guest;
        logic [bst_pkg::ADDR_W-1:0]   addr;
        logic [bst_pkg::KIND_W-1:0]   mask;
        logic [bst_pkg::WORD_W-1:0]   word;
        bit                           typed;
        bst_pkg::t_res                reply;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;   // address[31:0], kind_mask[34:32], original_word[66:35]
    logic [2:0]  i_s_tuser = '0;   // command[1:0], guest_id[2]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // status[1:0], kinds_out[4:2], saved_word[36:5]

    logic                       trap_slot_on    [bst_pkg::GUESTS][bst_pkg::SLOTS] =
                                    '{default: '0};
    logic [bst_pkg::ADDR_W-1:0] trap_slot_addr  [bst_pkg::GUESTS][bst_pkg::SLOTS];
    logic [bst_pkg::KIND_W-1:0] trap_slot_kinds [bst_pkg::GUESTS][bst_pkg::SLOTS];
    logic [bst_pkg::WORD_W-1:0] trap_slot_word  [bst_pkg::GUESTS][bst_pkg::SLOTS];

    bst_pkg::t_res              owed_replies[$];
    logic [bst_pkg::ADDR_W-1:0] trap_pool[bst_pkg::GUESTS][POOL_N];
    t_stim_row                  directed_rows[14];
    int                         errors = 0;
    int                         idle_cycles = 0;
    int                         reply_stall = 0;
    bit                         steady_flow = 1'b0;

    breakpoint_slot_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic bst_pkg::t_res resolve_trap_cmd(input bst_pkg::t_req r);
        bst_pkg::t_res res;
        int            hit;
        int            hole;
        int            g;
        res  = '0;
        hit  = -1;
        hole = -1;
        g    = int'(r.guest_id);
        for (int s = bst_pkg::SLOTS - 1; s >= 0; s--) begin
            if (trap_slot_on[g][s] && trap_slot_addr[g][s] == r.address)
                hit = s;
            if (!trap_slot_on[g][s])
                hole = s;
        end
        case (r.command)
            bst_pkg::CMD_STORE: begin
                if (hit >= 0) begin
                    trap_slot_kinds[g][hit] = trap_slot_kinds[g][hit] | r.kind_mask;
                    res = '{bst_pkg::ST_MERGED, trap_slot_kinds[g][hit],
                            trap_slot_word[g][hit]};
                end else if (hole >= 0) begin
                    trap_slot_on[g][hole]    = 1'b1;
                    trap_slot_addr[g][hole]  = r.address;
                    trap_slot_kinds[g][hole] = r.kind_mask;
                    trap_slot_word[g][hole]  = r.original_word;
                    res = '{bst_pkg::ST_NEW, r.kind_mask, r.original_word};
                end else begin
                    res.status = bst_pkg::ST_FULL;
                end
            end
            bst_pkg::CMD_QUERY: begin
                if (hit >= 0)
                    res = '{bst_pkg::ST_FOUND, trap_slot_kinds[g][hit],
                            trap_slot_word[g][hit]};
                else
                    res.status = bst_pkg::ST_MISS;
            end
            bst_pkg::CMD_CLEAN: begin
                if (hit >= 0) begin
                    trap_slot_kinds[g][hit] = trap_slot_kinds[g][hit] & ~r.kind_mask;
                    res.saved_word = trap_slot_word[g][hit];
                    if (trap_slot_kinds[g][hit] == '0) begin
                        trap_slot_on[g][hit] = 1'b0;
                        res.status = bst_pkg::ST_FREED;
                    end else begin
                        res.status    = bst_pkg::ST_KEPT;
                        res.kinds_out = trap_slot_kinds[g][hit];
                    end
                end else begin
                    res.status = bst_pkg::ST_GONE;
                end
            end
            default: res.status = bst_pkg::ST_BADCMD;
        endcase
        return res;
    endfunction

    task automatic issue_cmd(input bst_pkg::t_req r, input bit typed,
                             input bst_pkg::t_res typed_reply);
        int            gap;
        bst_pkg::t_res predicted;
        gap = pick_gap(steady_flow);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, r.original_word, r.kind_mask, r.address};
        i_s_tuser  <= {r.guest_id, r.command};
        do @(posedge i_clk); while (!o_s_tready);
        predicted = resolve_trap_cmd(r);
        owed_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic check_reply();
        bst_pkg::t_res got;
        bst_pkg::t_res want;
        got = '{o_m_tdata[1:0], o_m_tdata[4:2], o_m_tdata[36:5]};
        if (owed_replies.size() == 0) begin
            $display("%0t: unexpected reply, expected none, got %h", $time, got);
            errors++;
        end else begin
            want = owed_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.kinds_out !== want.kinds_out) begin
                $display("%0t: kinds expected %0d, got %0d",
                         $time, want.kinds_out, got.kinds_out);
                errors++;
            end
            if (got.saved_word !== want.saved_word) begin
                $display("%0t: saved word expected %h, got %h",
                         $time, want.saved_word, got.saved_word);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                check_reply();
            if (reply_stall > 0) begin
                reply_stall <= reply_stall - 1;
                i_m_tready  <= 1'b0;
            end else begin
                reply_stall <= pick_gap(steady_flow);
                i_m_tready  <= 1'b1;
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        bst_pkg::t_req req;
        int            roll;
        int            store_cut;
        directed_rows[0]  = '{bst_pkg::CMD_QUERY, 1'b0, 32'h0, 3'd0, 32'h0, 1'b1,
                              '{bst_pkg::ST_MISS, 3'd0, 32'h0}};
        directed_rows[1]  = '{bst_pkg::CMD_CLEAN, 1'b1, 32'hFFFF_FFFF, 3'd7, 32'h0, 1'b1,
                              '{bst_pkg::ST_GONE, 3'd0, 32'h0}};
        directed_rows[2]  = '{bst_pkg::CMD_NONE, 1'b1, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF,
                              1'b1, '{bst_pkg::ST_BADCMD, 3'd0, 32'h0}};
        directed_rows[3]  = '{bst_pkg::CMD_STORE, 1'b0, 32'h0, 3'd0, 32'hFFFF_FFFF, 1'b1,
                              '{bst_pkg::ST_NEW, 3'd0, 32'hFFFF_FFFF}};
        directed_rows[4]  = '{bst_pkg::CMD_QUERY, 1'b0, 32'h0, 3'd7, 32'h0, 1'b0, '0};
        directed_rows[5]  = '{bst_pkg::CMD_STORE, 1'b0, 32'h0, 3'd7, 32'h0, 1'b0, '0};
        directed_rows[6]  = '{bst_pkg::CMD_STORE, 1'b1, 32'hFFFF_FFFF, 3'd1, 32'h0, 1'b1,
                              '{bst_pkg::ST_NEW, 3'd1, 32'h0}};
        directed_rows[7]  = '{bst_pkg::CMD_QUERY, 1'b0, 32'hFFFF_FFFF, 3'd0, 32'h0, 1'b0,
                              '0};
        directed_rows[8]  = '{bst_pkg::CMD_CLEAN, 1'b1, 32'hFFFF_FFFF, 3'd0, 32'h0, 1'b0,
                              '0};
        directed_rows[9]  = '{bst_pkg::CMD_CLEAN, 1'b0, 32'h0, 3'd2, 32'h0, 1'b0, '0};
        directed_rows[10] = '{bst_pkg::CMD_CLEAN, 1'b0, 32'h0, 3'd5, 32'h0, 1'b0, '0};
        directed_rows[11] = '{bst_pkg::CMD_CLEAN, 1'b0, 32'h0, 3'd7, 32'h0, 1'b0, '0};
        directed_rows[12] = '{bst_pkg::CMD_STORE, 1'b0, 32'h0, 3'd0, 32'h5A5A_A5A5, 1'b0,
                              '0};
        directed_rows[13] = '{bst_pkg::CMD_CLEAN, 1'b0, 32'h0, 3'd0, 32'h0, 1'b0, '0};
        foreach (trap_pool[g, k])
            trap_pool[g][k] = $urandom;
        trap_pool[0][0]        = 32'h0;
        trap_pool[1][POOL_N-1] = 32'hFFFF_FFFF;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            req = '{directed_rows[i].cmd, directed_rows[i].guest, directed_rows[i].addr,
                    directed_rows[i].mask, directed_rows[i].word};
            issue_cmd(req, directed_rows[i].typed, directed_rows[i].reply);
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            steady_flow = (i % 350) < 70;
            if (i == RAND_ITEMS / 2) begin
                i_s_tvalid <= 1'b0;
                while (owed_replies.size() != 0) @(posedge i_clk);
            end
            case ((i / 250) % 3)
                0:       store_cut = 70;
                1:       store_cut = 40;
                default: store_cut = 25;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < store_cut)
                req.command = bst_pkg::CMD_STORE;
            else if (roll < store_cut + 20)
                req.command = bst_pkg::CMD_QUERY;
            else if (roll < 95)
                req.command = bst_pkg::CMD_CLEAN;
            else
                req.command = bst_pkg::CMD_NONE;
            req.guest_id      = bst_pkg::GUEST_W'($urandom_range(0, bst_pkg::GUESTS - 1));
            req.address       = ($urandom_range(0, 99) < 85) ?
                                trap_pool[req.guest_id][$urandom_range(0, POOL_N - 1)] :
                                $urandom;
            req.kind_mask     = bst_pkg::KIND_W'($urandom_range(0, 7));
            req.original_word = $urandom;
            issue_cmd(req, 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;

        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (bst_pkg::SLOTS + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
src/bst_pkg.sv
src/bst_slot_mem.sv
src/bst_ctrl.sv
src/breakpoint_slot_table.sv
verif/breakpoint_slot_table_test.sv
